/* sv/wcbs_pkg.sv */
package wcbs_pkg;

    // sizes
    localparam int MAX_ITEMS       = 64;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ADDR_W          = $clog2(MAX_ITEMS);
    localparam int CNT_W           = $clog2(MAX_ITEMS + 1);
    localparam int CI_W            = $clog2(TRIG_ITERATIONS);

    // field widths
    localparam int BEARING_W = 17;
    localparam int QUALITY_W = 25;
    localparam int BOUT_W    = 16;
    localparam int INDEX_W   = 6;
    localparam int WIN_W     = 7;
    localparam int TOL_W     = 4;

    // datapath widths
    localparam int SUM_W    = 40;
    localparam int SQS_W    = 64;
    localparam int MUL_W    = 72;
    localparam int MB_W     = 40;
    localparam int L_W      = 42;
    localparam int CORD_W   = 34;
    localparam int TRIG_W   = 18;
    localparam int PROD_W   = 44;
    localparam int ACC_W    = 52;
    localparam int WEIGHT_W = 27;
    localparam int DIVN_W   = 41;
    localparam int DREM_W   = 26;
    localparam int DCNT_W   = $clog2(DIVN_W + 1);

    // angle and scale constants
    localparam int FULL_TURN       = 46080;
    localparam int HALF_TURN       = 23040;
    localparam int QUARTER_TURN    = 11520;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int ONE_Q16         = 65536;
    localparam int HALF_TURN_Q20   = 180 << 20;
    localparam int NORM_LIM        = 1 << 30;
    localparam int ROUND_Q13       = 4096;

    // register indexes
    localparam logic [0:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [0:0] CFG_OUTLIER_TOL = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_NQ,
        ST_SS,
        ST_DT,
        ST_RD,
        ST_L,
        ST_LL,
        ST_WT,
        ST_DIV,
        ST_CS,
        ST_CSF,
        ST_PX,
        ST_PY,
        ST_ORD,
        ST_OSEL,
        ST_AREQ,
        ST_AADD,
        ST_NORM,
        ST_VEC,
        ST_AFIN,
        ST_EMIT
    } t_state;

    // arctangent of 2^-i in degrees, Q20
    function automatic logic signed [CORD_W-1:0] atan_q20(input logic [4:0] idx);
        logic signed [CORD_W-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd47185920;
                5'd1:  v = 34'sd27855475;
                5'd2:  v = 34'sd14718068;
                5'd3:  v = 34'sd7471121;
                5'd4:  v = 34'sd3750058;
                5'd5:  v = 34'sd1876857;
                5'd6:  v = 34'sd938658;
                5'd7:  v = 34'sd469357;
                5'd8:  v = 34'sd234682;
                5'd9:  v = 34'sd117342;
                5'd10: v = 34'sd58671;
                5'd11: v = 34'sd29335;
                5'd12: v = 34'sd14668;
                5'd13: v = 34'sd7334;
                5'd14: v = 34'sd3667;
                5'd15: v = 34'sd1833;
                5'd16: v = 34'sd917;
                5'd17: v = 34'sd458;
                5'd18: v = 34'sd229;
                5'd19: v = 34'sd115;
                5'd20: v = 34'sd57;
                5'd21: v = 34'sd29;
                5'd22: v = 34'sd14;
                5'd23: v = 34'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // fold an angle below two full turns into (-180, 180]
    function automatic logic signed [BOUT_W-1:0] wrap_deg(input logic signed [23:0] a);
        logic signed [23:0] r;
        begin
            r = a;
            if (r >= FULL_TURN) r = 24'(r - FULL_TURN);
            else if (r <= -FULL_TURN) r = 24'(r + FULL_TURN);
            if (r > HALF_TURN) r = 24'(r - FULL_TURN);
            if (r <= -HALF_TURN) r = 24'(r + FULL_TURN);
            return BOUT_W'(r);
        end
    endfunction

endpackage

/* sv/wcbs_ram.sv */
module wcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/weighted_circular_bearing_smoother_core.sv */
// Weighted circular bearing smoother.
// Input channel (i_in_valid / o_in_stall): one bearing, quality and manual flag per
// beat, one beat per cycle while loading; i_last_in closes the sequence. Items past
// the store depth are dropped, but a dropped last beat still starts the run.
// After the last beat o_in_stall stays high until the final result is taken.
// Output channel (o_out_valid / i_out_stall): one beat per stored item, in order,
// with o_last_out on the final one; a stalled beat is held in its registers.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data): write while no run is active.
// Sequence: setup forms count times square sum, sum squared, and the difference
// times tolerance squared, each a shift-add over the multiplier bits; then per
// stored item a shift-add square of the deviation, a restoring divide for weighted
// items, a CORDIC rotation and two shift-add products; then per result, when
// smoothed, the window sum, normalize shifts and CORDIC vectoring. One shift-add
// multiplier, one divider and one CORDIC stage do all the work under the sequencer.
// Reset: window size 5, tolerance 3, stores empty, ready to load; no clearing pass.
module weighted_circular_bearing_smoother_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [wcbs_pkg::BEARING_W-1:0] i_bearing_in,
    input  logic signed [wcbs_pkg::QUALITY_W-1:0] i_quality_in,
    input  logic                                  i_manual_flag,
    input  logic                                  i_last_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [wcbs_pkg::INDEX_W-1:0]          o_item_index,
    output logic signed [wcbs_pkg::BOUT_W-1:0]    o_bearing_out,
    output logic                                  o_zero_max_error,
    output logic                                  o_last_out,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_index,
    input  logic [wcbs_pkg::WIN_W-1:0]            i_cfg_data
);

    localparam int ADDR_W   = wcbs_pkg::ADDR_W;
    localparam int CNT_W    = wcbs_pkg::CNT_W;
    localparam int CI_W     = wcbs_pkg::CI_W;
    localparam int SUM_W    = wcbs_pkg::SUM_W;
    localparam int SQS_W    = wcbs_pkg::SQS_W;
    localparam int MUL_W    = wcbs_pkg::MUL_W;
    localparam int MB_W     = wcbs_pkg::MB_W;
    localparam int L_W      = wcbs_pkg::L_W;
    localparam int CORD_W   = wcbs_pkg::CORD_W;
    localparam int TRIG_W   = wcbs_pkg::TRIG_W;
    localparam int PROD_W   = wcbs_pkg::PROD_W;
    localparam int ACC_W    = wcbs_pkg::ACC_W;
    localparam int WEIGHT_W = wcbs_pkg::WEIGHT_W;
    localparam int DIVN_W   = wcbs_pkg::DIVN_W;
    localparam int DREM_W   = wcbs_pkg::DREM_W;
    localparam int DCNT_W   = wcbs_pkg::DCNT_W;
    localparam int QW       = wcbs_pkg::QUALITY_W;
    localparam int BW       = wcbs_pkg::BEARING_W;
    localparam int WIN_W    = wcbs_pkg::WIN_W;
    localparam int TOL_W    = wcbs_pkg::TOL_W;

    wcbs_pkg::t_state r_state, n_state;

    logic [WIN_W-1:0]          r_win, n_win;
    logic [TOL_W-1:0]          r_tol, n_tol;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [SQS_W-1:0]          r_sqs, n_sqs;
    logic signed [QW-1:0]      r_max, n_max;

    logic [MUL_W-1:0]          r_ma, n_ma;
    logic [MB_W-1:0]           r_mb, n_mb;
    logic [MUL_W-1:0]          r_mp, n_mp;
    logic                      r_psgn, n_psgn;
    logic [SQS_W-1:0]          r_nq, n_nq;
    logic [SQS_W-1:0]          r_d, n_d;
    logic [MUL_W-1:0]          r_dt, n_dt;

    logic [CNT_W-1:0]          r_i, n_i;
    logic signed [L_W-1:0]     r_l, n_l;
    logic                      r_outl, n_outl;
    logic signed [WEIGHT_W-1:0] r_w, n_w;

    logic [DREM_W-1:0]         r_drem, n_drem;
    logic [DIVN_W-1:0]         r_dq, n_dq;
    logic [DCNT_W-1:0]         r_dcnt, n_dcnt;
    logic                      r_dneg, n_dneg;

    logic signed [CORD_W-1:0]  r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [CI_W-1:0]           r_ci, n_ci;
    logic                      r_crot, n_crot;
    logic                      r_neg, n_neg;
    logic signed [TRIG_W-1:0]  r_c, n_c, r_s, n_s;

    logic [CNT_W-1:0]          r_k, n_k;
    logic [WIN_W-1:0]          r_krem, n_krem;
    logic signed [ACC_W-1:0]   r_sx, n_sx, r_sy, n_sy;
    logic signed [wcbs_pkg::BOUT_W-1:0] r_res, n_res;

    // memory side
    logic signed [BW-1:0]      w_b;
    logic signed [QW-1:0]      w_q;
    logic                      w_man;
    logic signed [PROD_W-1:0]  w_px, w_py, w_prod;
    logic                      w_store, w_px_we, w_py_we;

    // shared helpers
    logic                      w_in_acc;
    logic                      w_err;
    logic [WIN_W-1:0]          w_win;
    logic [2*TOL_W-1:0]        w_tol2;
    logic signed [2*QW-1:0]    w_qsq;
    logic                      w_mul_done;
    logic signed [CORD_W-1:0]  w_dx, w_dy, w_ang;
    logic                      w_up, w_ci_last;
    logic signed [CORD_W-1:0]  w_cx_step, w_cy_step, w_cz_step;
    logic signed [CORD_W-1:0]  w_rz;
    logic                      w_rneg;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_store    = w_in_acc && (r_cnt < CNT_W'(wcbs_pkg::MAX_ITEMS));
    assign w_err      = (r_max == '0);
    assign w_win      = (r_win == '0) ? WIN_W'(1) : r_win;
    assign w_tol2     = r_tol * r_tol;
    assign w_qsq      = i_quality_in * i_quality_in;
    assign w_mul_done = (r_mb == '0);
    assign w_prod     = r_psgn ? -PROD_W'(r_mp) : PROD_W'(r_mp);
    assign w_px_we    = (r_state == wcbs_pkg::ST_PX) && w_mul_done;
    assign w_py_we    = (r_state == wcbs_pkg::ST_PY) && w_mul_done;

    // shared cordic stage, rotation or vectoring
    assign w_dx      = r_cy >>> r_ci;
    assign w_dy      = r_cx >>> r_ci;
    assign w_ang     = wcbs_pkg::atan_q20(5'(r_ci));
    assign w_up      = r_crot ? (r_cz >= 0) : (r_cy <= 0);
    assign w_cx_step = w_up ? r_cx - w_dx : r_cx + w_dx;
    assign w_cy_step = w_up ? r_cy + w_dy : r_cy - w_dy;
    assign w_cz_step = w_up ? r_cz - w_ang : r_cz + w_ang;
    assign w_ci_last = (r_ci == CI_W'(wcbs_pkg::TRIG_ITERATIONS - 1));

    // angle reduction for the sine/cosine start
    always_comb begin
        logic signed [BW+1:0] v_r;
        v_r    = (BW+2)'(w_b);
        w_rneg = 1'b0;
        if (v_r >= wcbs_pkg::FULL_TURN) v_r = (BW+2)'(v_r - wcbs_pkg::FULL_TURN);
        else if (v_r <= -wcbs_pkg::FULL_TURN) v_r = (BW+2)'(v_r + wcbs_pkg::FULL_TURN);
        if (v_r >= wcbs_pkg::HALF_TURN) v_r = (BW+2)'(v_r - wcbs_pkg::FULL_TURN);
        if (v_r < -wcbs_pkg::HALF_TURN) v_r = (BW+2)'(v_r + wcbs_pkg::FULL_TURN);
        if (v_r > wcbs_pkg::QUARTER_TURN) begin
            v_r    = (BW+2)'(v_r - wcbs_pkg::HALF_TURN);
            w_rneg = 1'b1;
        end else if (v_r < -wcbs_pkg::QUARTER_TURN) begin
            v_r    = (BW+2)'(v_r + wcbs_pkg::HALF_TURN);
            w_rneg = 1'b1;
        end
        w_rz = CORD_W'(v_r) <<< 13;
    end

    // stores
    wcbs_ram #(.WIDTH(BW), .DEPTH(wcbs_pkg::MAX_ITEMS)) u_bearing (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(i_bearing_in), .i_raddr(r_i[ADDR_W-1:0]), .o_rdata(w_b)
    );
    wcbs_ram #(.WIDTH(QW), .DEPTH(wcbs_pkg::MAX_ITEMS)) u_quality (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(i_quality_in), .i_raddr(r_i[ADDR_W-1:0]), .o_rdata(w_q)
    );
    wcbs_ram #(.WIDTH(1), .DEPTH(wcbs_pkg::MAX_ITEMS)) u_manual (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(i_manual_flag), .i_raddr(r_i[ADDR_W-1:0]), .o_rdata(w_man)
    );
    wcbs_ram #(.WIDTH(PROD_W), .DEPTH(wcbs_pkg::MAX_ITEMS)) u_px (
        .i_clk(i_clk), .i_we(w_px_we), .i_waddr(r_i[ADDR_W-1:0]),
        .i_wdata(w_prod), .i_raddr(r_k[ADDR_W-1:0]), .o_rdata(w_px)
    );
    wcbs_ram #(.WIDTH(PROD_W), .DEPTH(wcbs_pkg::MAX_ITEMS)) u_py (
        .i_clk(i_clk), .i_we(w_py_we), .i_waddr(r_i[ADDR_W-1:0]),
        .i_wdata(w_prod), .i_raddr(r_k[ADDR_W-1:0]), .o_rdata(w_py)
    );

    // sequencer
    always_comb begin
        logic [SUM_W-1:0]         v_sabs;
        logic [SQS_W-1:0]         v_d;
        logic signed [L_W-1:0]    v_qe;
        logic signed [CNT_W:0]    v_ne;
        logic signed [L_W-1:0]    v_lnew;
        logic [L_W-1:0]           v_labs;
        logic [QW-1:0]            v_qabs;
        logic [DREM_W-1:0]        v_rem;
        logic                     v_qbit;
        logic [WEIGHT_W-1:0]      v_wabs;
        logic signed [CORD_W-1:0] v_xf, v_yf, v_z;
        logic signed [TRIG_W-1:0] v_c, v_s;
        logic [TRIG_W-1:0]        v_cabs;
        logic                     v_big;

        n_state = r_state;
        n_win = r_win;   n_tol = r_tol;   n_cnt = r_cnt;
        n_sum = r_sum;   n_sqs = r_sqs;   n_max = r_max;
        n_ma = r_ma;     n_mb = r_mb;     n_mp = r_mp;     n_psgn = r_psgn;
        n_nq = r_nq;     n_d = r_d;       n_dt = r_dt;
        n_i = r_i;       n_l = r_l;       n_outl = r_outl; n_w = r_w;
        n_drem = r_drem; n_dq = r_dq;     n_dcnt = r_dcnt; n_dneg = r_dneg;
        n_cx = r_cx;     n_cy = r_cy;     n_cz = r_cz;
        n_ci = r_ci;     n_crot = r_crot; n_neg = r_neg;
        n_c = r_c;       n_s = r_s;
        n_k = r_k;       n_krem = r_krem; n_sx = r_sx;     n_sy = r_sy;
        n_res = r_res;

        v_sabs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        v_d    = (r_nq > r_mp[SQS_W-1:0]) ? r_nq - r_mp[SQS_W-1:0] : '0;
        v_qe   = L_W'(w_q);
        v_ne   = {1'b0, r_cnt};
        v_lnew = v_qe * v_ne - L_W'(r_sum);
        v_labs = v_lnew[L_W-1] ? L_W'(-v_lnew) : L_W'(v_lnew);
        v_qabs = w_q[QW-1] ? QW'(-w_q) : QW'(w_q);
        v_rem  = {r_drem[DREM_W-2:0], r_dq[DIVN_W-1]};
        v_qbit = (v_rem >= DREM_W'(r_max));
        if (v_qbit) v_rem = v_rem - DREM_W'(r_max);
        v_wabs = r_w[WEIGHT_W-1] ? WEIGHT_W'(-r_w) : WEIGHT_W'(r_w);
        v_xf   = r_neg ? -r_cx : r_cx;
        v_yf   = r_neg ? -r_cy : r_cy;
        v_c    = TRIG_W'(v_xf >>> 15);
        v_s    = TRIG_W'(v_yf >>> 15);
        v_cabs = v_c[TRIG_W-1] ? TRIG_W'(-v_c) : TRIG_W'(v_c);
        v_big  = (r_sx >= wcbs_pkg::NORM_LIM) || (r_sx <= -wcbs_pkg::NORM_LIM) ||
                 (r_sy >= wcbs_pkg::NORM_LIM) || (r_sy <= -wcbs_pkg::NORM_LIM);
        v_z    = r_cz + CORD_W'(wcbs_pkg::ROUND_Q13);

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wcbs_pkg::CFG_WINDOW_SIZE: n_win = i_cfg_data;
                wcbs_pkg::CFG_OUTLIER_TOL: n_tol = i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end

        // shared shift-add multiplier step
        if (!w_mul_done) begin
            n_mp = r_mp + (r_mb[0] ? r_ma : '0);
            n_ma = r_ma << 1;
            n_mb = r_mb >> 1;
        end

        // shared cordic step
        if (r_state == wcbs_pkg::ST_CS || r_state == wcbs_pkg::ST_VEC) begin
            n_cx = w_cx_step;
            n_cy = w_cy_step;
            n_cz = w_cz_step;
            n_ci = r_ci + 1'b1;
        end

        unique case (r_state)
            wcbs_pkg::ST_LOAD: begin
                if (w_store) begin
                    n_cnt = r_cnt + 1'b1;
                    n_sum = r_sum + SUM_W'(i_quality_in);
                    n_sqs = r_sqs + SQS_W'($unsigned(w_qsq));
                    if (i_quality_in >= r_max) n_max = i_quality_in;
                end
                if (w_in_acc && i_last_in) begin
                    n_ma    = MUL_W'(n_sqs);
                    n_mb    = MB_W'(n_cnt);
                    n_mp    = '0;
                    n_state = wcbs_pkg::ST_NQ;
                end
            end
            wcbs_pkg::ST_NQ: begin
                if (w_mul_done) begin
                    n_nq    = r_mp[SQS_W-1:0];
                    n_ma    = MUL_W'(v_sabs);
                    n_mb    = MB_W'(v_sabs);
                    n_mp    = '0;
                    n_state = wcbs_pkg::ST_SS;
                end
            end
            wcbs_pkg::ST_SS: begin
                if (w_mul_done) begin
                    n_d     = v_d;
                    n_ma    = MUL_W'(v_d);
                    n_mb    = MB_W'(w_tol2);
                    n_mp    = '0;
                    n_state = wcbs_pkg::ST_DT;
                end
            end
            wcbs_pkg::ST_DT: begin
                if (w_mul_done) begin
                    n_dt    = r_mp;
                    n_i     = '0;
                    n_state = wcbs_pkg::ST_RD;
                end
            end
            wcbs_pkg::ST_RD: begin
                n_state = wcbs_pkg::ST_L;
            end
            // deviation of this quality from the mean, scaled by the count
            wcbs_pkg::ST_L: begin
                n_l     = v_lnew;
                n_ma    = MUL_W'(v_labs);
                n_mb    = MB_W'(v_labs);
                n_mp    = '0;
                n_state = wcbs_pkg::ST_LL;
            end
            wcbs_pkg::ST_LL: begin
                if (w_mul_done) begin
                    if (w_tol2 == '0 || r_d == '0) n_outl = !r_l[L_W-1];
                    else if (r_l[L_W-1]) n_outl = 1'b0;
                    else n_outl = (r_mp >= r_dt);
                    n_state = wcbs_pkg::ST_WT;
                end
            end
            wcbs_pkg::ST_WT: begin
                n_cx   = CORD_W'(wcbs_pkg::CORDIC_GAIN_Q30);
                n_cy   = '0;
                n_cz   = w_rz;
                n_ci   = '0;
                n_crot = 1'b1;
                n_neg  = w_rneg;
                if (w_man) begin
                    n_w     = WEIGHT_W'(wcbs_pkg::ONE_Q16);
                    n_state = wcbs_pkg::ST_CS;
                end else if (r_outl || w_err) begin
                    n_w     = '0;
                    n_state = wcbs_pkg::ST_CS;
                end else begin
                    n_dq    = (DIVN_W'(v_qabs) << 16) + DIVN_W'(r_max >>> 1);
                    n_drem  = '0;
                    n_dcnt  = '0;
                    n_dneg  = w_q[QW-1];
                    n_state = wcbs_pkg::ST_DIV;
                end
            end
            // restoring divide, one quotient bit a cycle
            wcbs_pkg::ST_DIV: begin
                if (r_dcnt == DCNT_W'(DIVN_W)) begin
                    n_w     = r_dneg ? -WEIGHT_W'(r_dq) : WEIGHT_W'(r_dq);
                    n_state = wcbs_pkg::ST_CS;
                end else begin
                    n_drem = v_rem;
                    n_dq   = {r_dq[DIVN_W-2:0], v_qbit};
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            wcbs_pkg::ST_CS: begin
                if (w_ci_last) n_state = wcbs_pkg::ST_CSF;
            end
            wcbs_pkg::ST_CSF: begin
                n_c     = v_c;
                n_s     = v_s;
                n_ma    = MUL_W'(v_cabs);
                n_mb    = MB_W'(v_wabs);
                n_mp    = '0;
                n_psgn  = v_c[TRIG_W-1] ^ r_w[WEIGHT_W-1];
                n_state = wcbs_pkg::ST_PX;
            end
            wcbs_pkg::ST_PX: begin
                if (w_mul_done) begin
                    n_ma    = MUL_W'(r_s[TRIG_W-1] ? TRIG_W'(-r_s) : TRIG_W'(r_s));
                    n_mb    = MB_W'(v_wabs);
                    n_mp    = '0;
                    n_psgn  = r_s[TRIG_W-1] ^ r_w[WEIGHT_W-1];
                    n_state = wcbs_pkg::ST_PY;
                end
            end
            wcbs_pkg::ST_PY: begin
                if (w_mul_done) begin
                    if (r_i == CNT_W'(r_cnt - 1'b1)) begin
                        n_i     = '0;
                        n_state = wcbs_pkg::ST_ORD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = wcbs_pkg::ST_RD;
                    end
                end
            end
            wcbs_pkg::ST_ORD: begin
                n_state = wcbs_pkg::ST_OSEL;
            end
            wcbs_pkg::ST_OSEL: begin
                if (!w_err && (int'(r_i) + int'(w_win) < int'(r_cnt))) begin
                    n_k     = r_i;
                    n_krem  = w_win;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_state = wcbs_pkg::ST_AREQ;
                end else begin
                    n_res   = wcbs_pkg::wrap_deg(24'(w_b));
                    n_state = wcbs_pkg::ST_EMIT;
                end
            end
            wcbs_pkg::ST_AREQ: begin
                n_state = wcbs_pkg::ST_AADD;
            end
            // window sums, one stored product pair a step
            wcbs_pkg::ST_AADD: begin
                n_sx   = r_sx + ACC_W'(w_px);
                n_sy   = r_sy + ACC_W'(w_py);
                n_k    = r_k + 1'b1;
                n_krem = r_krem - 1'b1;
                if (r_krem == WIN_W'(1)) n_state = wcbs_pkg::ST_NORM;
                else n_state = wcbs_pkg::ST_AREQ;
            end
            wcbs_pkg::ST_NORM: begin
                if (r_sx == '0 && r_sy == '0) begin
                    n_res   = '0;
                    n_state = wcbs_pkg::ST_EMIT;
                end else if (v_big) begin
                    n_sx = r_sx >>> 1;
                    n_sy = r_sy >>> 1;
                end else begin
                    n_ci   = '0;
                    n_crot = 1'b0;
                    if (r_sx < 0) begin
                        n_cz = (r_sy >= 0) ? CORD_W'(wcbs_pkg::HALF_TURN_Q20)
                                           : -CORD_W'(wcbs_pkg::HALF_TURN_Q20);
                        n_cx = -CORD_W'(r_sx);
                        n_cy = -CORD_W'(r_sy);
                    end else begin
                        n_cz = '0;
                        n_cx = CORD_W'(r_sx);
                        n_cy = CORD_W'(r_sy);
                    end
                    n_state = wcbs_pkg::ST_VEC;
                end
            end
            wcbs_pkg::ST_VEC: begin
                if (w_ci_last) n_state = wcbs_pkg::ST_AFIN;
            end
            wcbs_pkg::ST_AFIN: begin
                n_res   = wcbs_pkg::wrap_deg(24'(v_z >>> 13));
                n_state = wcbs_pkg::ST_EMIT;
            end
            wcbs_pkg::ST_EMIT: begin
                if (!i_out_stall) begin
                    if (r_i == CNT_W'(r_cnt - 1'b1)) begin
                        n_cnt   = '0;
                        n_sum   = '0;
                        n_sqs   = '0;
                        n_max   = '0;
                        n_state = wcbs_pkg::ST_LOAD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = wcbs_pkg::ST_ORD;
                    end
                end
            end
            default: n_state = wcbs_pkg::ST_LOAD;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcbs_pkg::ST_LOAD;
            r_win   <= WIN_W'(5);
            r_tol   <= TOL_W'(3);
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sqs   <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_tol   <= n_tol;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_sqs   <= n_sqs;
            r_max   <= n_max;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ma <= n_ma;     r_mb <= n_mb;     r_mp <= n_mp;     r_psgn <= n_psgn;
        r_nq <= n_nq;     r_d <= n_d;       r_dt <= n_dt;
        r_i <= n_i;       r_l <= n_l;       r_outl <= n_outl; r_w <= n_w;
        r_drem <= n_drem; r_dq <= n_dq;     r_dcnt <= n_dcnt; r_dneg <= n_dneg;
        r_cx <= n_cx;     r_cy <= n_cy;     r_cz <= n_cz;
        r_ci <= n_ci;     r_crot <= n_crot; r_neg <= n_neg;
        r_c <= n_c;       r_s <= n_s;
        r_k <= n_k;       r_krem <= n_krem; r_sx <= n_sx;     r_sy <= n_sy;
        r_res <= n_res;
    end

    // ports
    assign o_in_stall       = (r_state != wcbs_pkg::ST_LOAD);
    assign o_out_valid      = (r_state == wcbs_pkg::ST_EMIT);
    assign o_item_index     = wcbs_pkg::INDEX_W'(r_i);
    assign o_bearing_out    = r_res;
    assign o_zero_max_error = w_err;
    assign o_last_out       = (r_i == CNT_W'(r_cnt - 1'b1));

    // checks
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_i < r_cnt))
        else $error("result index beyond loaded count");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_in) |=> o_in_stall)
        else $error("last beat did not start the run");

    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_out) |=> (!o_in_stall && !o_out_valid))
        else $error("final result did not return to loading");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("loading while results are pending");

endmodule

/* tb/weighted_circular_bearing_smoother_core_tb.sv */
`timescale 1ns / 1ps

module weighted_circular_bearing_smoother_core_tb;
    import wcbs_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int NUM_ITEMS   = 180;

    typedef struct {
        logic [INDEX_W-1:0]       index;
        logic signed [BOUT_W-1:0] bearing;
        logic                     zero_max;
        logic                     last;
    } smooth_beat_t;

    // predicts the smoothed bearings of each loaded sequence and checks them
    class bearing_scoreboard;
        int           bearing_mem[MAX_ITEMS];
        int           quality_mem[MAX_ITEMS];
        bit           manual_mem[MAX_ITEMS];
        int           count;
        longint       q_sum;
        longint       q_sq_sum;
        longint       q_max;
        int           win;
        int           tol;
        smooth_beat_t expected_q[$];
        int           errors;

        function new();
            count = 0; q_sum = 0; q_sq_sum = 0; q_max = 0;
            win = 5; tol = 3; errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, int val);
            if (idx == CFG_WINDOW_SIZE) win = val & 8'h7f;
            else tol = val & 4'hf;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint fold_angle(longint a);
            longint r;
            r = a % FULL_TURN;
            if (r > HALF_TURN) r -= FULL_TURN;
            if (r <= -HALF_TURN) r += FULL_TURN;
            return r;
        endfunction

        // rotation cordic, gives q1.15 cosine and sine
        function void sin_cos(longint a, output longint c, output longint s);
            longint r, x, y, z, dx, dy;
            bit flip;
            r = a % FULL_TURN; x = CORDIC_GAIN_Q30; y = 0; flip = 0;
            if (r >= HALF_TURN) r -= FULL_TURN;
            if (r < -HALF_TURN) r += FULL_TURN;
            if (r > QUARTER_TURN) begin
                r -= HALF_TURN; flip = 1;
            end else if (r < -QUARTER_TURN) begin
                r += HALF_TURN; flip = 1;
            end
            z = r * 8192;
            for (int i = 0; i < TRIG_ITERATIONS; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_q20(i));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_q20(i));
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = x >>> 15;
            s = y >>> 15;
        endfunction

        // vectoring cordic, result in q9.7 degrees
        function longint vector_angle(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            while (x >= (64'sd1 << 30) || x <= -(64'sd1 << 30) ||
                   y >= (64'sd1 << 30) || y <= -(64'sd1 << 30)) begin
                x = x >>> 1; y = y >>> 1;
            end
            if (x < 0) begin
                z = (y >= 0) ? (64'sd180 << 20) : -(64'sd180 << 20);
                x = -x; y = -y;
            end
            for (int i = 0; i < TRIG_ITERATIONS; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(atan_q20(i));
                end else begin
                    x -= dx; y += dy; z -= longint'(atan_q20(i));
                end
            end
            return fold_angle((z + 4096) >>> 13);
        endfunction

        // accepted input beat; the last one of a sequence queues its results
        function void note_beat(int b, int q, bit m, bit l);
            longint weight[MAX_ITEMS];
            longint a, s2, d, tol2, dev, qi, mag, r, sx, sy, c, s, res;
            int n, w;
            bit err, outl;
            smooth_beat_t e;
            if (count < MAX_ITEMS) begin
                bearing_mem[count] = b; quality_mem[count] = q; manual_mem[count] = m;
                count++;
                q_sum += q;
                q_sq_sum += longint'(q) * longint'(q);
                if (q >= q_max) q_max = q;
            end
            if (!l) return;
            n = count;
            w = (win == 0) ? 1 : win;
            err = (q_max == 0);
            a = longint'(n) * q_sq_sum;
            s2 = q_sum * q_sum;
            d = (a > s2) ? a - s2 : 0;
            tol2 = tol * tol;
            // outlier test and normalized weights
            for (int i = 0; i < n; i++) begin
                qi = quality_mem[i];
                dev = qi * n - q_sum;
                if (tol2 == 0 || d == 0) outl = (dev >= 0);
                else if (dev < 0) outl = 0;
                else outl = (d <= (dev * dev) / tol2);
                if (manual_mem[i]) weight[i] = ONE_Q16;
                else if (outl || err) weight[i] = 0;
                else begin
                    mag = (qi < 0) ? -qi : qi;
                    r = ((mag << 16) + q_max / 2) / q_max;
                    weight[i] = (qi < 0) ? -r : r;
                end
            end
            // windowed circular mean, rest passes through
            for (int i = 0; i < n; i++) begin
                if (!err && n > w && i < n - w) begin
                    sx = 0; sy = 0;
                    for (int k = i; k < i + w; k++) begin
                        sin_cos(bearing_mem[k], c, s);
                        sx += c * weight[k];
                        sy += s * weight[k];
                    end
                    res = vector_angle(sy, sx);
                end else begin
                    res = fold_angle(bearing_mem[i]);
                end
                e.index = i; e.bearing = res[BOUT_W-1:0];
                e.zero_max = err; e.last = (i + 1 == n);
                expected_q.push_back(e);
            end
            count = 0; q_sum = 0; q_sq_sum = 0; q_max = 0;
        endfunction

        function void check_beat(smooth_beat_t got);
            smooth_beat_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result index %0d bearing %0d", $time,
                         got.index, got.bearing);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.index !== e.index) begin
                $display("%0t: item_index expected %0d actual %0d", $time, e.index, got.index);
                errors++;
            end
            if (got.bearing !== e.bearing) begin
                $display("%0t: bearing_out[%0d] expected %0d actual %0d", $time, e.index,
                         e.bearing, got.bearing);
                errors++;
            end
            if (got.zero_max !== e.zero_max) begin
                $display("%0t: zero_max_error[%0d] expected %0b actual %0b", $time, e.index,
                         e.zero_max, got.zero_max);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: last_out[%0d] expected %0b actual %0b", $time, e.index,
                         e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_in_valid = 0;
    logic                        o_in_stall;
    logic signed [BEARING_W-1:0] i_bearing_in = '0;
    logic signed [QUALITY_W-1:0] i_quality_in = '0;
    logic                        i_manual_flag = 0;
    logic                        i_last_in = 0;
    logic                        o_out_valid;
    logic                        i_out_stall = 0;
    logic [INDEX_W-1:0]          o_item_index;
    logic signed [BOUT_W-1:0]    o_bearing_out;
    logic                        o_zero_max_error;
    logic                        o_last_out;
    logic                        i_cfg_we = 0;
    logic [0:0]                  i_cfg_index = '0;
    logic [WIN_W-1:0]            i_cfg_data = '0;

    bearing_scoreboard sb = new();
    bit  gaps_on = 0;
    bit  long_hold = 0;
    int  cycles = 0;
    int  sent = 0;

    weighted_circular_bearing_smoother_core u_dut (.*);

    // clock
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        smooth_beat_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.index = o_item_index; got.bearing = o_bearing_out;
            got.zero_max = o_zero_max_error; got.last = o_last_out;
            sb.check_beat(got);
        end
    end

    // receiver stall bursts and one long hold-off
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall = 1;
                n = 0;
                while (n < 400) begin
                    @(negedge i_clk);
                    n++;
                end
                long_hold = 0;
                i_out_stall = 0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_out_stall = 0;
            end else begin
                i_out_stall = 0;
            end
        end
    end

    // one input beat, held until accepted
    task automatic send_beat(int b, int q, bit m, bit l);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 6) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_bearing_in = b; i_quality_in = q; i_manual_flag = m; i_last_in = l;
        i_in_valid = 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b, q, m, l);
        sent++;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_in_valid = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_index = idx; i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_phase(int w, int t);
        go_idle();
        write_reg(CFG_WINDOW_SIZE, w);
        write_reg(CFG_OUTLIER_TOL, t);
    endtask

    // one random sequence with clustered qualities and occasional outliers
    task automatic send_sequence(int len);
        int base, q, b;
        base = $urandom_range(256, 1 << 20);
        for (int i = 0; i < len; i++) begin
            b = $signed($urandom_range(0, 92160)) - 46080;
            case ($urandom_range(0, 19))
                0:       q = 16777215;
                1:       q = -$signed($urandom_range(1, 256));
                2:       q = $urandom_range(0, 16777215);
                default: q = base + $urandom_range(0, base / 4);
            endcase
            send_beat(b, q, $urandom_range(0, 6) == 0, i == len - 1);
        end
    endtask

    initial begin
        int len, seq;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // extremes of the fields at window size 2 and tolerance 3, with a negative weight
        set_phase(2, 3);
        send_beat(-46080, 16777215, 0, 0);
        send_beat(46080, -256, 0, 0);
        send_beat(0, 0, 1, 0);
        send_beat(23040, 256, 0, 0);
        send_beat(-23040, 1000, 0, 1);
        // single item sequence
        send_beat(12345, 512, 0, 1);
        // zero maximum quality
        send_beat(5000, 0, 0, 0);
        send_beat(-7000, -256, 1, 0);
        send_beat(30000, 0, 0, 1);
        // zero tolerance, equal qualities: all weights zero, sums zero
        set_phase(1, 0);
        repeat (3) send_beat(9000, 4096, 0, 0);
        send_beat(-9000, 4096, 0, 1);
        // window size zero acts as one, window not shorter than sequence
        set_phase(0, 15);
        send_beat(100, 300, 0, 0);
        send_beat(-100, 200, 0, 1);
        set_phase(64, 1);
        send_beat(44000, 700, 0, 0);
        send_beat(-44000, 800, 1, 1);

        // random part over several settings
        gaps_on = 1;
        seq = 0;
        while (sent < NUM_ITEMS) begin
            if (seq % 5 == 0)
                set_phase($urandom_range(0, 9) == 0 ? 63 : $urandom_range(1, 8),
                          $urandom_range(0, 15));
            if (seq == 3) long_hold = 1;
            if (seq == 6) go_idle();
            if (NUM_ITEMS - sent < 40) gaps_on = 0;
            if (seq == 8) len = 66;
            else if ($urandom_range(0, 15) == 0) len = $urandom_range(30, 64);
            else len = $urandom_range(2, 12);
            send_sequence(len);
            seq++;
        end
        gaps_on = 0;

        go_idle();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
